### rtl/cht_pkg.sv
package cht_pkg;

    localparam int HASH_BITS    = 64;
    localparam int VALUE_BITS   = 64;
    localparam int CMD_BITS     = 2;
    localparam int STATUS_BITS  = 2;
    localparam int CFG_BITS     = 9;
    localparam int DEF_BUCKETS  = 256;
    localparam int DEF_ENTRIES  = 1024;
    localparam int DEF_KEY_BITS = 64;

    localparam int RDX_BITS     = 4;
    localparam int DIV_STEPS    = HASH_BITS / RDX_BITS;
    localparam int DIV_CNT_BITS = $clog2(DIV_STEPS);

    localparam int APB_ADDR_BITS = 3;
    localparam int APB_DATA_BITS = 32;
    localparam logic [APB_ADDR_BITS-3:0] REG_BUCKET_COUNT = '0;
    localparam logic [CFG_BITS-1:0] BUCKET_COUNT_RESET = 9'd256;

    localparam logic [CMD_BITS-1:0] CMD_GET = 2'd0;
    localparam logic [CMD_BITS-1:0] CMD_SET = 2'd1;
    localparam logic [CMD_BITS-1:0] CMD_DEL = 2'd2;

    localparam logic [STATUS_BITS-1:0] STATUS_OK   = 2'd0;
    localparam logic [STATUS_BITS-1:0] STATUS_MISS = 2'd1;
    localparam logic [STATUS_BITS-1:0] STATUS_FULL = 2'd2;

    // pool write address select
    localparam logic [1:0] WA_USED  = 2'd0;
    localparam logic [1:0] WA_EMPTY = 2'd1;
    localparam logic [1:0] WA_LINK  = 2'd2;
    localparam logic [1:0] WA_LAST  = 2'd3;

    typedef struct packed {
        logic                   clr_wr;
        logic                   accept;
        logic                   div_step;
        logic                   head_rd;
        logic                   head_link;
        logic                   pool_rd;
        logic                   walk_init;
        logic                   walk_adv;
        logic [1:0]             wa_sel;
        logic                   wr_keyhash;
        logic                   wr_value;
        logic                   wr_del;
        logic                   del_bit;
        logic                   wr_next;
        logic                   next_link;
        logic                   used_inc;
        logic                   res_set;
        logic [STATUS_BITS-1:0] res_status;
        logic                   res_value;
        logic                   out_load;
    } t_ctl;

    typedef struct packed {
        logic                clr_last;
        logic                div_done;
        logic                head_ok;
        logic                hit;
        logic                live;
        logic                next_cont;
        logic                empty_set;
        logic                full;
        logic                last_null;
        logic [CMD_BITS-1:0] cmd;
        logic                out_free;
    } t_sts;

endpackage

### rtl/cht_datapath.sv
module cht_datapath import cht_pkg::*; #(
    parameter int BUCKETS  = DEF_BUCKETS,
    parameter int ENTRIES  = DEF_ENTRIES,
    parameter int KEY_BITS = DEF_KEY_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_ctl                   i_ctl,
    output t_sts                   o_sts,
    input  logic [CFG_BITS-1:0]    i_bucket_count,
    input  logic [CMD_BITS-1:0]    i_command,
    input  logic [63:0]            i_key,
    input  logic [HASH_BITS-1:0]   i_key_hash,
    input  logic [VALUE_BITS-1:0]  i_value,
    input  logic                   i_out_stall,
    output logic                   o_out_valid,
    output logic [STATUS_BITS-1:0] o_status,
    output logic [VALUE_BITS-1:0]  o_read_value
);

    localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int NW = $clog2(BUCKETS + 1);
    localparam int AW = $clog2(ENTRIES);
    localparam int LW = $clog2(ENTRIES + 1);
    localparam logic [LW-1:0] LINK_MAX = LW'(ENTRIES);
    localparam logic [BW-1:0] CLR_LAST = BW'(BUCKETS - 1);

    logic [LW-1:0]         r_heads [BUCKETS];
    logic [KEY_BITS-1:0]   r_keys  [ENTRIES];
    logic [HASH_BITS-1:0]  r_hashes[ENTRIES];
    logic [VALUE_BITS-1:0] r_values[ENTRIES];
    logic                  r_dels  [ENTRIES];
    logic [LW-1:0]         r_nexts [ENTRIES];

    logic [CMD_BITS-1:0]    r_cmd;
    logic [KEY_BITS-1:0]    r_key;
    logic [HASH_BITS-1:0]   r_hash;
    logic [VALUE_BITS-1:0]  r_value;
    logic [HASH_BITS-1:0]   r_dividend;
    logic [NW-1:0]          r_div;
    logic [NW-1:0]          r_rem;
    logic [DIV_CNT_BITS-1:0] r_div_cnt;
    logic [BW-1:0]          r_clr_addr;
    logic [LW-1:0]          r_head_q;
    logic [LW-1:0]          r_link;
    logic [LW-1:0]          r_last;
    logic [LW-1:0]          r_empty;
    logic [LW-1:0]          r_steps;
    logic [LW-1:0]          r_used;
    logic [KEY_BITS-1:0]    r_rd_key;
    logic [HASH_BITS-1:0]   r_rd_hash;
    logic [VALUE_BITS-1:0]  r_rd_value;
    logic                   r_rd_del;
    logic [LW-1:0]          r_rd_next;
    logic [STATUS_BITS-1:0] r_res_status;
    logic [VALUE_BITS-1:0]  r_res_value;
    logic                   r_out_valid;
    logic [STATUS_BITS-1:0] r_out_status;
    logic [VALUE_BITS-1:0]  r_out_value;

    logic [NW-1:0]  div_load;
    logic [NW-1:0]  rem_n;
    logic [NW:0]    t;
    logic [BW-1:0]  bucket;
    logic [BW-1:0]  hd_addr;
    logic [LW-1:0]  empty_m1;
    logic [LW-1:0]  link_m1;
    logic [LW-1:0]  last_m1;
    logic [AW-1:0]  wa;
    logic [AW-1:0]  ra;

    always_comb begin
        if (i_bucket_count == '0) begin
            div_load = NW'(1);
        end else if (32'(i_bucket_count) > 32'(BUCKETS)) begin
            div_load = NW'(BUCKETS);
        end else begin
            div_load = NW'(i_bucket_count);
        end
    end

    // radix-16 restoring remainder
    always_comb begin
        t     = '0;
        rem_n = r_rem;
        for (int j = 0; j < RDX_BITS; j++) begin
            t = {rem_n, r_dividend[HASH_BITS-1-j]};
            if (t >= {1'b0, r_div}) begin
                t = t - {1'b0, r_div};
            end
            rem_n = t[NW-1:0];
        end
    end

    assign bucket   = r_rem[BW-1:0];
    assign hd_addr  = i_ctl.clr_wr ? r_clr_addr : bucket;
    assign empty_m1 = r_empty - LW'(1);
    assign link_m1  = r_link - LW'(1);
    assign last_m1  = r_last - LW'(1);
    assign ra       = link_m1[AW-1:0];

    always_comb begin
        unique case (i_ctl.wa_sel)
            WA_USED:  wa = r_used[AW-1:0];
            WA_EMPTY: wa = empty_m1[AW-1:0];
            WA_LINK:  wa = link_m1[AW-1:0];
            WA_LAST:  wa = last_m1[AW-1:0];
            default:  wa = r_used[AW-1:0];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.clr_wr || i_ctl.head_link) begin
            r_heads[hd_addr] <= i_ctl.clr_wr ? '0 : r_used;
        end
        if (i_ctl.head_rd) begin
            r_head_q <= r_heads[bucket];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_keyhash) begin
            r_keys[wa]   <= r_key;
            r_hashes[wa] <= r_hash;
        end
        if (i_ctl.wr_value) begin
            r_values[wa] <= r_value;
        end
        if (i_ctl.wr_del) begin
            r_dels[wa] <= i_ctl.del_bit;
        end
        if (i_ctl.wr_next) begin
            r_nexts[wa] <= i_ctl.next_link ? r_used : '0;
        end
        if (i_ctl.pool_rd) begin
            r_rd_key   <= r_keys[ra];
            r_rd_hash  <= r_hashes[ra];
            r_rd_value <= r_values[ra];
            r_rd_del   <= r_dels[ra];
            r_rd_next  <= r_nexts[ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.accept) begin
            r_cmd      <= i_command;
            r_key      <= i_key[KEY_BITS-1:0];
            r_hash     <= i_key_hash;
            r_value    <= i_value;
            r_dividend <= i_key_hash;
            r_div      <= div_load;
            r_rem      <= '0;
            r_div_cnt  <= '0;
        end else if (i_ctl.div_step) begin
            r_dividend <= r_dividend << RDX_BITS;
            r_rem      <= rem_n;
            r_div_cnt  <= r_div_cnt + DIV_CNT_BITS'(1);
        end
        if (i_ctl.walk_init) begin
            r_link  <= r_head_q;
            r_steps <= '0;
            r_empty <= '0;
            r_last  <= '0;
        end else if (i_ctl.walk_adv) begin
            r_link  <= r_rd_next;
            r_steps <= r_steps + LW'(1);
            r_empty <= r_rd_del ? r_link : r_empty;
            r_last  <= r_link;
        end
        if (i_ctl.res_set) begin
            r_res_status <= i_ctl.res_status;
            r_res_value  <= i_ctl.res_value ? r_rd_value : '0;
        end
        if (i_ctl.out_load) begin
            r_out_status <= r_res_status;
            r_out_value  <= r_res_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr  <= '0;
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_ctl.clr_wr) begin
                r_clr_addr <= r_clr_addr + BW'(1);
            end
            if (i_ctl.used_inc) begin
                r_used <= r_used + LW'(1);
            end
            r_out_valid <= i_ctl.out_load || (r_out_valid && i_out_stall);
        end
    end

    assign o_sts.clr_last  = (r_clr_addr == CLR_LAST);
    assign o_sts.div_done  = (r_div_cnt == DIV_CNT_BITS'(DIV_STEPS - 1));
    assign o_sts.head_ok   = (r_head_q != '0) && (r_head_q <= LINK_MAX);
    assign o_sts.hit       = (r_rd_hash == r_hash) && (r_rd_key == r_key);
    assign o_sts.live      = !r_rd_del;
    assign o_sts.next_cont = (r_rd_next != '0) && (r_rd_next <= LINK_MAX)
                           && ((32'(r_steps) + 32'd1) < 32'(ENTRIES));
    assign o_sts.empty_set = (r_empty != '0);
    assign o_sts.full      = (r_used == LINK_MAX);
    assign o_sts.last_null = (r_last == '0);
    assign o_sts.cmd       = r_cmd;
    assign o_sts.out_free  = !r_out_valid || !i_out_stall;

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_out_status;
    assign o_read_value = r_out_value;

endmodule

### rtl/cht_ctrl.sv
module cht_ctrl import cht_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_sts i_sts,
    output t_ctl o_ctl
);

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_DIV   = 4'd2;
    localparam logic [3:0] S_HEAD  = 4'd3;
    localparam logic [3:0] S_HCHK  = 4'd4;
    localparam logic [3:0] S_RD    = 4'd5;
    localparam logic [3:0] S_CHK   = 4'd6;
    localparam logic [3:0] S_END   = 4'd7;
    localparam logic [3:0] S_ALLOC = 4'd8;
    localparam logic [3:0] S_LINK  = 4'd9;
    localparam logic [3:0] S_DONE  = 4'd10;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        o_ctl   = '0;
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                o_ctl.clr_wr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_ctl.accept = 1'b1;
                    n_state      = S_DIV;
                end
            end
            S_DIV: begin
                o_ctl.div_step = 1'b1;
                if (i_sts.div_done) begin
                    n_state = S_HEAD;
                end
            end
            S_HEAD: begin
                o_ctl.head_rd = 1'b1;
                n_state       = S_HCHK;
            end
            S_HCHK: begin
                o_ctl.walk_init = 1'b1;
                if (i_sts.cmd != CMD_GET && i_sts.cmd != CMD_SET
                        && i_sts.cmd != CMD_DEL) begin
                    o_ctl.res_set    = 1'b1;
                    o_ctl.res_status = STATUS_MISS;
                    n_state          = S_DONE;
                end else if (i_sts.head_ok) begin
                    n_state = S_RD;
                end else if (i_sts.cmd == CMD_SET) begin
                    if (i_sts.full) begin
                        o_ctl.res_set    = 1'b1;
                        o_ctl.res_status = STATUS_FULL;
                        n_state          = S_DONE;
                    end else begin
                        n_state = S_ALLOC;
                    end
                end else begin
                    o_ctl.res_set    = 1'b1;
                    o_ctl.res_status = STATUS_MISS;
                    n_state          = S_DONE;
                end
            end
            S_RD: begin
                o_ctl.pool_rd = 1'b1;
                n_state       = S_CHK;
            end
            S_CHK: begin
                if (i_sts.cmd == CMD_SET && i_sts.hit) begin
                    o_ctl.wa_sel     = WA_LINK;
                    o_ctl.wr_value   = 1'b1;
                    o_ctl.wr_del     = 1'b1;
                    o_ctl.res_set    = 1'b1;
                    o_ctl.res_status = STATUS_OK;
                    n_state          = S_DONE;
                end else if (i_sts.cmd == CMD_GET && i_sts.hit && i_sts.live) begin
                    o_ctl.res_set    = 1'b1;
                    o_ctl.res_status = STATUS_OK;
                    o_ctl.res_value  = 1'b1;
                    n_state          = S_DONE;
                end else if (i_sts.cmd == CMD_DEL && i_sts.hit && i_sts.live) begin
                    o_ctl.wa_sel     = WA_LINK;
                    o_ctl.wr_del     = 1'b1;
                    o_ctl.del_bit    = 1'b1;
                    o_ctl.res_set    = 1'b1;
                    o_ctl.res_status = STATUS_OK;
                    n_state          = S_DONE;
                end else begin
                    o_ctl.walk_adv = 1'b1;
                    n_state        = i_sts.next_cont ? S_RD : S_END;
                end
            end
            S_END: begin
                o_ctl.res_set = 1'b1;
                n_state       = S_DONE;
                if (i_sts.cmd != CMD_SET) begin
                    o_ctl.res_status = STATUS_MISS;
                end else if (i_sts.empty_set) begin
                    o_ctl.wa_sel     = WA_EMPTY;
                    o_ctl.wr_keyhash = 1'b1;
                    o_ctl.wr_value   = 1'b1;
                    o_ctl.wr_del     = 1'b1;
                    o_ctl.res_status = STATUS_OK;
                end else if (i_sts.full) begin
                    o_ctl.res_status = STATUS_FULL;
                end else begin
                    o_ctl.res_set = 1'b0;
                    n_state       = S_ALLOC;
                end
            end
            S_ALLOC: begin
                o_ctl.wa_sel     = WA_USED;
                o_ctl.wr_keyhash = 1'b1;
                o_ctl.wr_value   = 1'b1;
                o_ctl.wr_del     = 1'b1;
                o_ctl.wr_next    = 1'b1;
                o_ctl.used_inc   = 1'b1;
                n_state          = S_LINK;
            end
            S_LINK: begin
                if (i_sts.last_null) begin
                    o_ctl.head_link = 1'b1;
                end else begin
                    o_ctl.wa_sel    = WA_LAST;
                    o_ctl.wr_next   = 1'b1;
                    o_ctl.next_link = 1'b1;
                end
                o_ctl.res_set    = 1'b1;
                o_ctl.res_status = STATUS_OK;
                n_state          = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_ctl.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

endmodule

### rtl/chained_hash_table.sv
// Key-value table with separate chaining over a fixed pool of ENTRIES slots.
// Each item carries a command (get, set, delete), a key, its hash and a value;
// exactly one result item (status, read value) comes back per item, in order.
// After reset the block clears the bucket head memory and takes no item
// until that pass ends. For each item a radix-16 remainder unit maps the
// hash onto bucket_count buckets (clamped to 1..BUCKETS), RDX_BITS hash
// bits per step; each chain entry walked then takes a read and then a
// compare on the pool memory. A walk that reaches the end of its chain
// without a match passes an end step, and a set that appends a new slot
// goes through an alloc and then a link step. One item is in work at a
// time; a finished result waits in the output register while the next
// item is taken. bucket_count lies at byte address 0.
module chained_hash_table import cht_pkg::*; #(
    parameter int BUCKETS  = DEF_BUCKETS,
    parameter int ENTRIES  = DEF_ENTRIES,
    parameter int KEY_BITS = DEF_KEY_BITS
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [CMD_BITS-1:0]      i_command,
    input  logic [63:0]              i_key,
    input  logic [HASH_BITS-1:0]     i_key_hash,
    input  logic [VALUE_BITS-1:0]    i_value,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic [STATUS_BITS-1:0]   o_status,
    output logic [VALUE_BITS-1:0]    o_read_value,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready
);

    logic [CFG_BITS-1:0] r_bucket_count;
    logic                reg_hit;
    t_ctl                ctl;
    t_sts                sts;

    assign reg_hit = (paddr[APB_ADDR_BITS-1:2] == REG_BUCKET_COUNT);
    assign pready  = 1'b1;
    assign prdata  = reg_hit ? {{(APB_DATA_BITS-CFG_BITS){1'b0}}, r_bucket_count} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bucket_count <= BUCKET_COUNT_RESET;
        end else if (psel && penable && pwrite && reg_hit) begin
            r_bucket_count <= pwdata[CFG_BITS-1:0];
        end
    end

    cht_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_ctl      (ctl)
    );

    cht_datapath #(
        .BUCKETS  (BUCKETS),
        .ENTRIES  (ENTRIES),
        .KEY_BITS (KEY_BITS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (ctl),
        .o_sts          (sts),
        .i_bucket_count (r_bucket_count),
        .i_command      (i_command),
        .i_key          (i_key),
        .i_key_hash     (i_key_hash),
        .i_value        (i_value),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_status       (o_status),
        .o_read_value   (o_read_value)
    );

endmodule

### rtl/cht_checker.sv
module cht_checker import cht_pkg::*; (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_in_valid,
    input logic                   o_in_stall,
    input logic                   o_out_valid,
    input logic                   i_out_stall,
    input logic [STATUS_BITS-1:0] o_status,
    input logic [VALUE_BITS-1:0]  o_read_value
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_status)
            && $stable(o_read_value))
        else $error("result changed while stalled");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status == STATUS_OK || o_status == STATUS_MISS
            || o_status == STATUS_FULL))
        else $error("bad status code");

    a_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != STATUS_OK |-> o_read_value == '0)
        else $error("read value not zero on failure");

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second item taken while one is in work");

endmodule

bind chained_hash_table cht_checker u_cht_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_stall   (o_in_stall),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_status     (o_status),
    .o_read_value (o_read_value)
);
